>>> rtl/core/swbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swbf_pkg
// Shared sizes, codes and controller/datapath handshake structs for the
// sliding-window Bloom filter.
// ----------------------------------------------------------------------------
package swbf_pkg;

    localparam int ROW_CELLS   = 1024;
    localparam int IDX_W       = $clog2(ROW_CELLS);
    localparam int MAX_ROWS    = 8;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int ADDR_W      = IDX_W + ROW_W;
    localparam int STORE_CELLS = MAX_ROWS * ROW_CELLS;
    localparam int CELL_W      = 2;
    localparam int TIME_W      = 32;
    localparam int CPS_W       = 16;
    localparam int RIU_W       = 4;
    localparam int CFG_W       = 16;
    localparam int MOD_W       = TIME_W + 1 - IDX_W;
    localparam int MCNT_W      = $clog2(MOD_W + 1);
    localparam int SCAN_W      = ROW_W + 1;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_WINDOW = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic {
        CFG_ROWS_IN_USE    = 1'b0,
        CFG_CELLS_PER_STEP = 1'b1
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_INS_RD, S_INS_WR, S_MUL, S_CMP, S_FIRST_RD,
        S_FIRST_WR, S_MOD1, S_CHK, S_BULK, S_MOD2, S_SW_RD, S_SW_WR,
        S_WK, S_Q_RD, S_Q_USE, S_SCAN, S_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic rd_ptr;
        logic wr_set;
        logic wr_sweep;
        logic wr_clr;
        logic clr_reset;
        logic calc_k;
        logic mul;
        logic cmp_load;
        logic n_dec;
        logic ptr_adv;
        logic mod_start1;
        logic mod_start2;
        logic ptr_mod;
        logic q_use;
        logic scan_step;
        logic out_load;
    } t_dp_ctrl;

    typedef struct packed {
        logic in_valid;
        t_cmd in_cmd;
        t_cmd item_cmd;
        logic row_last;
        logic clr_last_all;
        logic clr_last_span;
        logic tick_ahead;
        logic ptr_out;
        logic bulk;
        logic n_zero;
        logic n_one;
        logic mod_done;
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

>>> rtl/core/swbf_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swbf_req_if
// Request channel: command, arrival time and pre-hashed row indices.
// ----------------------------------------------------------------------------
interface swbf_req_if;
    import swbf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           cmd;
    logic [TIME_W-1:0]    arrival_time;
    logic [IDX_W-1:0]     row_index_0;
    logic [IDX_W-1:0]     row_index_1;
    logic [IDX_W-1:0]     row_index_2;
    logic [IDX_W-1:0]     row_index_3;
    logic [IDX_W-1:0]     row_index_4;
    logic [IDX_W-1:0]     row_index_5;
    logic [IDX_W-1:0]     row_index_6;
    logic [IDX_W-1:0]     row_index_7;

    modport source (
        output valid, cmd, arrival_time, row_index_0, row_index_1, row_index_2,
               row_index_3, row_index_4, row_index_5, row_index_6, row_index_7,
        input  ready
    );
    modport sink (
        input  valid, cmd, arrival_time, row_index_0, row_index_1, row_index_2,
               row_index_3, row_index_4, row_index_5, row_index_6, row_index_7,
        output ready
    );
endinterface
`default_nettype wire

>>> rtl/core/swbf_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swbf_rsp_if
// Response channel: query hit flag.
// ----------------------------------------------------------------------------
interface swbf_rsp_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface
`default_nettype wire

>>> rtl/core/swbf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swbf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module swbf_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/core/swbf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swbf_datapath
// Cell store, sweep pointer, tick counter, modulo unit and result register.
// ----------------------------------------------------------------------------
module swbf_datapath (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic                    i_cfg_index,
    input  wire logic [swbf_pkg::CFG_W-1:0] i_cfg_data,
    input  wire swbf_pkg::t_dp_ctrl      i_ctrl,
    output swbf_pkg::t_dp_stat           o_stat,
    swbf_req_if.sink                     i_req,
    swbf_rsp_if.source                   o_rsp
);
    import swbf_pkg::*;

    logic [RIU_W-1:0]  r_rows_cfg;
    logic [CPS_W-1:0]  r_cps;
    t_cmd              r_cmd;
    logic [TIME_W-1:0] r_time;
    logic [IDX_W-1:0]  r_idx [MAX_ROWS];
    logic [ROW_W-1:0]  r_row;
    logic [ROW_W-1:0]  r_k;
    logic [MAX_ROWS-1:0] r_pbits;
    logic [MAX_ROWS-1:0] r_fbits;
    logic [SCAN_W-1:0] r_scan;
    logic [SCAN_W-1:0] r_run;
    logic              r_hit;
    logic [ADDR_W-1:0] r_ptr;
    logic [TIME_W-1:0] r_tick;
    logic [TIME_W-1:0] r_target;
    logic [TIME_W-1:0] r_n;
    logic [ADDR_W-1:0] r_clr;
    logic [MOD_W-1:0]  r_mq;
    logic [IDX_W-1:0]  r_mlow;
    logic [ROW_W-1:0]  r_mrem;
    logic [MCNT_W-1:0] r_mcnt;
    logic              r_ovalid;
    logic              r_ohit;

    logic [RIU_W-1:0]  rows_act;
    logic [ADDR_W:0]   span;
    logic [ROW_W-1:0]  k0;
    logic [RIU_W-1:0]  rsum;
    logic [ROW_W-1:0]  rowsel;
    logic [ADDR_W-1:0] row_addr;
    logic [CELL_W-1:0] rdata;
    logic              ram_we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
    logic [TIME_W-1:0] t1;
    logic [TIME_W+CPS_W-1:0] prod;
    logic [ADDR_W:0]   ptr_nxt;
    logic [TIME_W:0]   mod_x;
    logic [ROW_W:0]    mod_t;
    logic [SCAN_W-1:0] scan_off;
    logic              scan_bit;
    logic [SCAN_W-1:0] run_nxt;
    logic              accept;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= RIU_W'(4);
            r_cps      <= CPS_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ROWS_IN_USE:    r_rows_cfg <= i_cfg_data[RIU_W-1:0];
                CFG_CELLS_PER_STEP: r_cps      <= i_cfg_data[CPS_W-1:0];
                default:            r_cps      <= r_cps;
            endcase
        end
    end

    // clamp active rows and derive sweep span
    always_comb begin
        if (r_rows_cfg == '0) begin
            rows_act = RIU_W'(1);
        end else if (r_rows_cfg > RIU_W'(MAX_ROWS)) begin
            rows_act = RIU_W'(MAX_ROWS);
        end else begin
            rows_act = r_rows_cfg;
        end
        span = {rows_act, IDX_W'(0)};
    end

    // row selection and cell address
    always_comb begin
        k0 = r_ptr[ADDR_W-1:IDX_W];
        if ({1'b0, k0} >= rows_act) begin
            k0 = '0;
        end
        rsum = {1'b0, r_k} + {1'b0, r_row};
        if (rsum >= rows_act) begin
            rsum = rsum - rows_act;
        end
        if (i_ctrl.calc_k) begin
            rowsel = k0;
        end else if (r_cmd == CMD_WINDOW) begin
            rowsel = rsum[ROW_W-1:0];
        end else begin
            rowsel = r_row;
        end
        row_addr = {rowsel, r_idx[rowsel]};
    end

    // memory port muxing
    always_comb begin
        ram_we = i_ctrl.wr_set | i_ctrl.wr_sweep | i_ctrl.wr_clr;
        if (i_ctrl.wr_clr) begin
            waddr = r_clr;
        end else if (i_ctrl.wr_sweep) begin
            waddr = r_ptr;
        end else begin
            waddr = row_addr;
        end
        if (i_ctrl.wr_set) begin
            wdata = rdata | CELL_W'(1);
        end else if (i_ctrl.wr_sweep) begin
            wdata = {rdata[0], 1'b0};
        end else begin
            wdata = '0;
        end
        raddr = i_ctrl.rd_ptr ? r_ptr : row_addr;
    end

    swbf_ram #(
        .WIDTH(CELL_W),
        .DEPTH(STORE_CELLS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // arithmetic helpers
    always_comb begin
        t1      = r_time + TIME_W'(1);
        prod    = t1 * r_cps;
        ptr_nxt = {1'b0, r_ptr} + (ADDR_W+1)'(1);
        if (i_ctrl.mod_start2) begin
            mod_x = {1'b0, r_n} + (TIME_W+1)'(r_ptr);
        end else begin
            mod_x = (TIME_W+1)'(r_ptr) + (TIME_W+1)'(1);
        end
        mod_t = {r_mrem, r_mq[MOD_W-1]};
        if (mod_t >= rows_act) begin
            mod_t = mod_t - rows_act;
        end
        scan_off = r_scan - SCAN_W'(rows_act);
        if (r_scan < SCAN_W'(rows_act)) begin
            scan_bit = r_pbits[r_scan[ROW_W-1:0]];
        end else begin
            scan_bit = r_fbits[scan_off[ROW_W-1:0]];
        end
        run_nxt = scan_bit ? (r_run + SCAN_W'(1)) : '0;
    end

    assign accept      = i_req.valid & i_req.ready;
    assign i_req.ready = i_ctrl.in_ready;

    // item registers, row loop and query evaluation
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= t_cmd'(i_req.cmd);
            r_time   <= i_req.arrival_time;
            r_idx[0] <= i_req.row_index_0;
            r_idx[1] <= i_req.row_index_1;
            r_idx[2] <= i_req.row_index_2;
            r_idx[3] <= i_req.row_index_3;
            r_idx[4] <= i_req.row_index_4;
            r_idx[5] <= i_req.row_index_5;
            r_idx[6] <= i_req.row_index_6;
            r_idx[7] <= i_req.row_index_7;
            r_row    <= '0;
            r_k      <= '0;
            r_hit    <= (t_cmd'(i_req.cmd) == CMD_QUERY);
            r_pbits  <= '0;
            r_fbits  <= '0;
            r_scan   <= '0;
            r_run    <= '0;
        end else begin
            if (i_ctrl.wr_set) begin
                r_row <= r_row + ROW_W'(1);
            end
            if (i_ctrl.calc_k) begin
                if ({k0, r_idx[k0]} < r_ptr) begin
                    r_k <= ({1'b0, k0} + RIU_W'(1) == rows_act) ?
                           '0 : k0 + ROW_W'(1);
                end else begin
                    r_k <= k0;
                end
            end
            if (i_ctrl.q_use) begin
                r_row <= r_row + ROW_W'(1);
                if (r_cmd == CMD_WINDOW) begin
                    r_pbits[r_row] <= rdata[1];
                    r_fbits[r_row] <= rdata[0];
                end else if (rdata == '0) begin
                    r_hit <= 1'b0;
                end
            end
            if (i_ctrl.scan_step) begin
                r_scan <= r_scan + SCAN_W'(1);
                r_run  <= run_nxt;
                if (scan_bit && run_nxt >= SCAN_W'(rows_act)) begin
                    r_hit <= 1'b1;
                end
            end
        end
        if (i_ctrl.mul) begin
            r_target <= prod[TIME_W-1:0];
        end
    end

    // sweep pointer, tick counter, clear counter and modulo unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_tick <= '0;
            r_clr  <= '0;
            r_mcnt <= '0;
        end else begin
            if (i_ctrl.cmp_load) begin
                r_tick <= r_target;
            end
            if (i_ctrl.clr_reset) begin
                r_clr <= '0;
            end else if (i_ctrl.wr_clr) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (i_ctrl.ptr_adv) begin
                r_ptr <= (ptr_nxt == span) ? '0 : ptr_nxt[ADDR_W-1:0];
            end else if (i_ctrl.ptr_mod) begin
                r_ptr <= {r_mrem, r_mlow};
            end
            if (i_ctrl.mod_start1 || i_ctrl.mod_start2) begin
                r_mcnt <= MCNT_W'(MOD_W);
            end else if (r_mcnt != '0) begin
                r_mcnt <= r_mcnt - MCNT_W'(1);
            end
        end
    end

    // remaining tick count and modulo working registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_load) begin
            r_n <= r_target - r_tick;
        end else if (i_ctrl.n_dec) begin
            r_n <= r_n - TIME_W'(1);
        end
        if (i_ctrl.mod_start1 || i_ctrl.mod_start2) begin
            r_mq   <= mod_x[TIME_W:IDX_W];
            r_mlow <= mod_x[IDX_W-1:0];
            r_mrem <= '0;
        end else if (r_mcnt != '0) begin
            r_mq   <= {r_mq[MOD_W-2:0], 1'b0};
            r_mrem <= mod_t[ROW_W-1:0];
        end
    end

    // result register, parts the datapath from the response channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctrl.out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
        if (i_ctrl.out_load) begin
            r_ohit <= r_hit;
        end
    end

    assign o_rsp.valid = r_ovalid;
    assign o_rsp.hit   = r_ohit;

    // status back to the controller
    always_comb begin
        o_stat.in_valid      = i_req.valid;
        o_stat.in_cmd        = t_cmd'(i_req.cmd);
        o_stat.item_cmd      = r_cmd;
        o_stat.row_last      = ({1'b0, r_row} == rows_act - RIU_W'(1));
        o_stat.clr_last_all  = (r_clr == '1);
        o_stat.clr_last_span = ({1'b0, r_clr} == span - (ADDR_W+1)'(1));
        o_stat.tick_ahead    = (r_target > r_tick);
        o_stat.ptr_out       = ({1'b0, r_ptr} >= span);
        o_stat.bulk          = (r_n >= TIME_W'({span, 1'b0}));
        o_stat.n_zero        = (r_n == '0);
        o_stat.n_one         = (r_n == TIME_W'(1));
        o_stat.mod_done      = (r_mcnt == '0);
        o_stat.scan_last     = ({1'b0, r_scan} == {rows_act, 1'b0} - (RIU_W+1)'(1));
        o_stat.out_free      = ~r_ovalid | o_rsp.ready;
    end

`ifndef ASSERT_OFF
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_ctrl.wr_set, i_ctrl.wr_sweep, i_ctrl.wr_clr}))
        else $error("more than one store write source active");
    a_n_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.n_dec |-> (r_n != '0))
        else $error("tick budget decremented below zero");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.out_load |=> r_ovalid)
        else $error("result register not valid after load");
`endif
endmodule
`default_nettype wire

>>> rtl/core/swbf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swbf_ctrl
// Sequencer: reset clear pass, row loops, sweep and window scan.
// ----------------------------------------------------------------------------
module swbf_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire swbf_pkg::t_dp_stat i_stat,
    output swbf_pkg::t_dp_ctrl      o_ctrl
);
    import swbf_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        case (r_state)
            S_CLEAR: begin
                o_ctrl.wr_clr = 1'b1;
                if (i_stat.clr_last_all) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ctrl.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    case (i_stat.in_cmd)
                        CMD_INSERT: n_state = S_INS_RD;
                        CMD_QUERY:  n_state = S_Q_RD;
                        CMD_WINDOW: n_state = S_WK;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_INS_RD: n_state = S_INS_WR;
            S_INS_WR: begin
                o_ctrl.wr_set = 1'b1;
                n_state = i_stat.row_last ? S_MUL : S_INS_RD;
            end
            S_MUL: begin
                o_ctrl.mul = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (!i_stat.tick_ahead) begin
                    n_state = S_IDLE;
                end else begin
                    o_ctrl.cmp_load = 1'b1;
                    n_state = i_stat.ptr_out ? S_FIRST_RD : S_CHK;
                end
            end
            S_FIRST_RD: begin
                o_ctrl.rd_ptr = 1'b1;
                n_state = S_FIRST_WR;
            end
            S_FIRST_WR: begin
                o_ctrl.wr_sweep   = 1'b1;
                o_ctrl.n_dec      = 1'b1;
                o_ctrl.mod_start1 = 1'b1;
                n_state = S_MOD1;
            end
            S_MOD1: begin
                if (i_stat.mod_done) begin
                    o_ctrl.ptr_mod = 1'b1;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.bulk) begin
                    o_ctrl.clr_reset = 1'b1;
                    n_state = S_BULK;
                end else if (i_stat.n_zero) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SW_RD;
                end
            end
            S_BULK: begin
                o_ctrl.wr_clr = 1'b1;
                if (i_stat.clr_last_span) begin
                    o_ctrl.mod_start2 = 1'b1;
                    n_state = S_MOD2;
                end
            end
            S_MOD2: begin
                if (i_stat.mod_done) begin
                    o_ctrl.ptr_mod = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SW_RD: begin
                o_ctrl.rd_ptr = 1'b1;
                n_state = S_SW_WR;
            end
            S_SW_WR: begin
                o_ctrl.wr_sweep = 1'b1;
                o_ctrl.ptr_adv  = 1'b1;
                o_ctrl.n_dec    = 1'b1;
                n_state = i_stat.n_one ? S_IDLE : S_SW_RD;
            end
            S_WK: begin
                o_ctrl.calc_k = 1'b1;
                n_state = S_Q_RD;
            end
            S_Q_RD: n_state = S_Q_USE;
            S_Q_USE: begin
                o_ctrl.q_use = 1'b1;
                if (i_stat.row_last) begin
                    n_state = (i_stat.item_cmd == CMD_WINDOW) ? S_SCAN : S_DONE;
                end else begin
                    n_state = S_Q_RD;
                end
            end
            S_SCAN: begin
                o_ctrl.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_ctrl.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    a_idle_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> i_stat.mod_done)
        else $error("modulo unit busy while idle");
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_stat.out_free) |=> (r_state == S_DONE))
        else $error("result dropped while output register full");
    a_sweep_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SW_RD) |-> !i_stat.n_zero)
        else $error("sweep started with no ticks left");
`endif
endmodule
`default_nettype wire

>>> rtl/core/sliding_window_bloom_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_bloom_filter
// Sliding-window Bloom filter over 2-bit cells with a sweeping clock pointer.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one transaction per item: cmd (insert, plain query, window
//   query), arrival_time and eight pre-hashed row indices. o_rsp returns one
//   hit flag per query; inserts and unknown commands return nothing.
//   Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data; the user
//   must write it only while the block is idle, which the block does not enforce.
// Sequence: a plain query reads one cell per active row; a window query
//   first picks its start row from the sweep pointer, reads every active
//   row and scans the bits read. An insert sets its cells, then sweeps the
//   pointer up to the target tick cell by cell, or clears the active span
//   when the sweep covers two full windows or more; a pointer beyond the
//   active rows is first swept once and wrapped into them.
//   One item is in work at a time; the next is taken when the sequencer
//   returns to idle.
// Reset: the store is cleared in a pass over all 8192 cells; i_req.ready stays low
//   until it ends. A stalled o_rsp holds its result; the next item is still
//   accepted and runs until its own result needs the output register.
// ----------------------------------------------------------------------------
module sliding_window_bloom_filter (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_index,
    input  wire logic [swbf_pkg::CFG_W-1:0] i_cfg_data,
    swbf_req_if.sink                        i_req,
    swbf_rsp_if.source                      o_rsp
);
    import swbf_pkg::*;

    t_dp_ctrl ctrl;
    t_dp_stat stat;

    swbf_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_stat (stat),
        .o_ctrl (ctrl)
    );

    swbf_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_ctrl     (ctrl),
        .o_stat     (stat),
        .i_req      (i_req),
        .o_rsp      (o_rsp)
    );
endmodule
`default_nettype wire

>>> tb/sliding_window_bloom_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_bloom_filter_test
// Drives inserts, plain queries and window queries into the filter, keeps its
// own model of the cell store, sweep pointer and tick count, and checks every
// hit flag in order. A short table of directed items comes first, then random
// phases over several row counts and step sizes, with random idling on both
// channels and one long output stall.
// ----------------------------------------------------------------------------
module sliding_window_bloom_filter_test;
    import swbf_pkg::*;

    localparam int        CLK_HALF    = 10;
    localparam longint    CYCLE_LIMIT = 4000000;
    localparam int        N_PHASES    = 8;
    localparam int        HOLD_LEN    = 3000;

    typedef struct packed {
        t_cmd                       cmd;
        logic [TIME_W-1:0]          at;
        logic [MAX_ROWS-1:0][IDX_W-1:0] ri;
    } t_item;

    typedef struct {
        t_item item;
        bit    has_hit;
        bit    hit;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_index = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    swbf_req_if req ();
    swbf_rsp_if rsp ();

    sliding_window_bloom_filter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req.sink),
        .o_rsp       (rsp.source)
    );

    // filter model state
    logic [CELL_W-1:0] cells [STORE_CELLS];
    int unsigned       sweep_ptr;
    logic [31:0]       ticks;
    logic [3:0]        rows_cfg;
    logic [15:0]       step_cfg;
    int unsigned       last_work;

    bit                hits_due [$];
    t_item             key_pool [$];
    t_row              dir_rows [$];
    int unsigned       errors = 0;
    int unsigned       hits_seen = 0;
    int unsigned       results_seen = 0;
    int unsigned       bulk_sweeps = 0;
    int unsigned       send_pct = 0;
    int unsigned       recv_pct = 0;
    int unsigned       hold_cycles = 0;
    bit                hold_go = 1'b0;
    longint            cycles = 0;

    // clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("sliding_window_bloom_filter verification failed");
            $finish;
        end
    end

    task automatic report(input string what);
        errors++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    function automatic int unsigned live_rows();
        if (rows_cfg == 0) return 1;
        if (rows_cfg > MAX_ROWS) return MAX_ROWS;
        return rows_cfg;
    endfunction

    function automatic int unsigned cell_at(t_item it, int unsigned r);
        return r * ROW_CELLS + it.ri[r];
    endfunction

    function automatic void sweep_cell(int unsigned span);
        int unsigned p;
        p = sweep_ptr % STORE_CELLS;
        cells[p] = {cells[p][0], 1'b0};
        sweep_ptr = (p + 1) % span;
    endfunction

    // move the clock pointer up to the target tick
    function automatic void advance_to(logic [31:0] target);
        int unsigned span;
        logic [31:0] n;
        span = live_rows() * ROW_CELLS;
        if (ticks >= target) return;
        n = target - ticks;
        ticks = target;
        if (sweep_ptr >= span) begin
            sweep_cell(span);
            n--;
            last_work += 30;
        end
        if (n >= 2 * span) begin
            for (int unsigned i = 0; i < span; i++) cells[i] = '0;
            sweep_ptr = 32'((64'(sweep_ptr) + n) % span);
            last_work += span + 40;
            bulk_sweeps++;
        end else begin
            for (int unsigned i = 0; i < n; i++) sweep_cell(span);
            last_work += 2 * n;
        end
    endfunction

    // apply one transaction to the model; returns 1 when a hit flag follows
    function automatic bit filter_apply(t_item it, output bit hit);
        int unsigned rows, k, run;
        bit bits [2*MAX_ROWS];
        logic [CELL_W-1:0] c;
        rows = live_rows();
        hit = 1'b0;
        last_work = 4 * rows + 40;
        case (it.cmd)
            CMD_INSERT: begin
                for (int unsigned r = 0; r < rows; r++) cells[cell_at(it, r)][0] = 1'b1;
                advance_to((it.at + 32'd1) * {16'd0, step_cfg});
                return 1'b0;
            end
            CMD_QUERY: begin
                hit = 1'b1;
                for (int unsigned r = 0; r < rows; r++)
                    if (cells[cell_at(it, r)] == '0) hit = 1'b0;
                return 1'b1;
            end
            CMD_WINDOW: begin
                k = sweep_ptr / ROW_CELLS;
                if (k >= rows) k = 0;
                if (cell_at(it, k) < sweep_ptr) k = (k + 1) % rows;
                for (int unsigned i = 0; i < rows; i++) begin
                    c = cells[cell_at(it, (k + i) % rows)];
                    bits[i] = c[1];
                    bits[i + rows] = c[0];
                end
                run = 0;
                for (int unsigned i = 0; i < 2 * rows; i++) begin
                    if (bits[i]) begin
                        run++;
                        if (run >= rows) hit = 1'b1;
                    end else begin
                        run = 0;
                    end
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // register write on the plain config port, model follows
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_ROWS_IN_USE) rows_cfg = val[3:0];
        else step_cfg = val[15:0];
    endtask

    // offer one transaction, hold it until accepted, then predict
    task automatic send(input t_item it, input bit has_hit, input bit typed_hit);
        bit hit;
        bit due;
        while ($urandom_range(99) < send_pct) begin
            req.valid = 1'b0;
            @(negedge i_clk);
        end
        req.valid = 1'b1;
        req.cmd = it.cmd;
        req.arrival_time = it.at;
        {req.row_index_7, req.row_index_6, req.row_index_5, req.row_index_4,
         req.row_index_3, req.row_index_2, req.row_index_1, req.row_index_0} = it.ri;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        due = filter_apply(it, hit);
        if (due) hits_due.push_back(has_hit ? typed_hit : hit);
        if (it.cmd == CMD_INSERT) begin
            key_pool.push_back(it);
            if (key_pool.size() > 24) void'(key_pool.pop_front());
        end
        @(negedge i_clk);
        req.valid = 1'b0;
    endtask

    // wait until every flag is back and the last insert has had time to sweep
    task automatic drain();
        int unsigned settle;
        while (hits_due.size() != 0) @(negedge i_clk);
        settle = last_work + 200;
        repeat (settle) @(negedge i_clk);
    endtask

    function automatic t_item random_item();
        t_item it;
        int unsigned sel;
        logic [31:0] base;
        sel = $urandom_range(99);
        if (sel < 40) it.cmd = CMD_INSERT;
        else if (sel < 68) it.cmd = CMD_QUERY;
        else if (sel < 96) it.cmd = CMD_WINDOW;
        else it.cmd = CMD_NONE;
        // mostly reuse recent keys so queries can hit
        if (key_pool.size() != 0 && $urandom_range(99) < 60) begin
            it.ri = key_pool[$urandom_range(key_pool.size() - 1)].ri;
            if ($urandom_range(3) == 0) it.ri[$urandom_range(MAX_ROWS - 1)] = IDX_W'($urandom);
        end else begin
            for (int r = 0; r < MAX_ROWS; r++) it.ri[r] = IDX_W'($urandom);
        end
        base = (step_cfg == 0) ? 32'd0 : ticks / step_cfg;
        sel = $urandom_range(99);
        if (sel < 3) it.at = $urandom;
        else if (sel < 8) it.at = base - $urandom_range(5);
        else if (step_cfg == 0) it.at = $urandom;
        else it.at = base + $urandom_range((48 / step_cfg) + 1);
        return it;
    endfunction

    function automatic t_row dir_row(t_cmd cmd, logic [31:0] at, logic [IDX_W-1:0] idx,
                                     bit has_hit, bit hit);
        t_row row;
        row.item.cmd = cmd;
        row.item.at = at;
        for (int r = 0; r < MAX_ROWS; r++) row.item.ri[r] = idx;
        row.has_hit = has_hit;
        row.hit = hit;
        return row;
    endfunction

    // receiver: random stalls, or one long hold-off once asked
    always @(negedge i_clk) begin
        if (hold_go && hold_cycles < HOLD_LEN) begin
            rsp.ready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end else begin
            rsp.ready <= ($urandom_range(99) >= recv_pct);
        end
    end

    // check each returned flag against the oldest expected one
    always @(posedge i_clk) begin
        if (i_rst_n && rsp.valid && rsp.ready) begin
            results_seen++;
            if (rsp.hit) hits_seen++;
            if (hits_due.size() == 0) begin
                report("hit flag returned with nothing outstanding");
            end else begin
                if (rsp.hit !== hits_due[0])
                    report($sformatf("hit got %b want %b", rsp.hit, hits_due[0]));
                void'(hits_due.pop_front());
            end
        end
    end

    initial begin
        int unsigned ph_rows  [N_PHASES] = '{4, 1, 8, 0, 15, 2, 8, 6};
        int unsigned ph_step  [N_PHASES] = '{1, 1, 3, 2, 5, 65535, 0, 1};
        int unsigned ph_count [N_PHASES] = '{150, 100, 150, 80, 120, 20, 60, 170};
        t_item it;

        req.valid = 1'b0;
        req.cmd = CMD_NONE;
        req.arrival_time = '0;
        {req.row_index_0, req.row_index_1, req.row_index_2, req.row_index_3,
         req.row_index_4, req.row_index_5, req.row_index_6, req.row_index_7} = '0;
        foreach (cells[i]) cells[i] = '0;
        sweep_ptr = 0;
        ticks = '0;
        rows_cfg = 4'd4;
        step_cfg = 16'd1;
        last_work = 0;

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table: empty store, extremes of index and time, unknown command,
        // target behind the tick count, and a long sweep
        dir_rows.push_back(dir_row(CMD_QUERY,  32'd0,          10'd0,     1, 1'b0));
        dir_rows.push_back(dir_row(CMD_WINDOW, 32'd0,          10'd1023,  1, 1'b0));
        dir_rows.push_back(dir_row(CMD_INSERT, 32'd0,          10'd1023,  0, 1'b0));
        dir_rows.push_back(dir_row(CMD_QUERY,  32'd0,          10'd1023,  1, 1'b1));
        dir_rows.push_back(dir_row(CMD_WINDOW, 32'd0,          10'd1023,  0, 1'b0));
        dir_rows.push_back(dir_row(CMD_QUERY,  32'hFFFF_FFFF,  10'd0,     1, 1'b0));
        dir_rows.push_back(dir_row(CMD_NONE,   32'd7,          10'd1023,  0, 1'b0));
        dir_rows.push_back(dir_row(CMD_INSERT, 32'hFFFF_FFFF,  10'h155,   0, 1'b0));
        dir_rows.push_back(dir_row(CMD_QUERY,  32'd0,          10'h155,   1, 1'b1));
        dir_rows.push_back(dir_row(CMD_INSERT, 32'd40,         10'h2AA,   0, 1'b0));
        dir_rows.push_back(dir_row(CMD_WINDOW, 32'd0,          10'h2AA,   0, 1'b0));
        dir_rows.push_back(dir_row(CMD_WINDOW, 32'd0,          10'd0,     0, 1'b0));
        dir_rows.push_back(dir_row(CMD_QUERY,  32'd0,          10'h2AA,   0, 1'b0));
        dir_rows.push_back(dir_row(CMD_INSERT, 32'd3000,       10'd5,     0, 1'b0));
        dir_rows.push_back(dir_row(CMD_QUERY,  32'd0,          10'd1023,  0, 1'b0));
        dir_rows.push_back(dir_row(CMD_WINDOW, 32'd0,          10'h155,   0, 1'b0));
        dir_rows.push_back(dir_row(CMD_WINDOW, 32'd0,          10'd5,     0, 1'b0));
        dir_rows.push_back(dir_row(CMD_QUERY,  32'd0,          10'd5,     0, 1'b0));
        foreach (dir_rows[i]) send(dir_rows[i].item, dir_rows[i].has_hit, dir_rows[i].hit);
        drain();

        // random phases over row counts and step sizes
        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph < 3) begin
                send_pct = 9;
                recv_pct = 65;
            end else if (ph < 6) begin
                send_pct = 65;
                recv_pct = 9;
            end else begin
                send_pct = 0;
                recv_pct = 0;
            end
            write_reg(CFG_ROWS_IN_USE, CFG_W'(ph_rows[ph]));
            write_reg(CFG_CELLS_PER_STEP, CFG_W'(ph_step[ph]));
            if (ph == N_PHASES - 1) hold_go = 1'b1;
            for (int n = 0; n < ph_count[ph]; n++) begin
                it = random_item();
                send(it, 0, 1'b0);
            end
            drain();
        end

        $display("items: %0d directed plus random over %0d settings; %0d flags, %0d hits",
                 dir_rows.size(), N_PHASES, results_seen, hits_seen);
        $display("full-window sweeps seen: %0d, mismatches: %0d", bulk_sweeps, errors);
        if (errors == 0) begin
            $display("sliding_window_bloom_filter verification clean");
        end else begin
            $display("sliding_window_bloom_filter verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/swbf_pkg.sv
rtl/core/swbf_req_if.sv
rtl/core/swbf_rsp_if.sv
rtl/core/swbf_ram.sv
rtl/core/swbf_datapath.sv
rtl/core/swbf_ctrl.sv
rtl/core/sliding_window_bloom_filter.sv
tb/sliding_window_bloom_filter_test.sv
